### sv/sspq_pkg.sv
// Shared types, constants and control structs for the stable sorted priority queue.
package sspq_pkg;

	localparam int DEPTH_DEF = 16;
	localparam int VALUE_W   = 32;
	localparam int PRIO_W    = 16;

	typedef logic signed [VALUE_W-1:0] value_t;
	typedef logic [PRIO_W-1:0]         prio_t;

	localparam logic   MODE_INSERT  = 1'b0;
	localparam logic   MODE_EXTRACT = 1'b1;
	localparam value_t EMPTY_VALUE  = '1;

	typedef struct packed {
		logic load;
		logic exec;
	} pq_cmd_t;

endpackage

### sv/sspq_in_if.sv
// Input channel: one operation beat (insert or extract).
interface sspq_in_if;
	import sspq_pkg::*;

	logic   valid;
	logic   ready;
	logic   mode;
	value_t item_value;
	prio_t  item_priority;

	modport source (output valid, output mode, output item_value, output item_priority,
		input ready);
	modport sink (input valid, input mode, input item_value, input item_priority,
		output ready);
endinterface

### sv/sspq_out_if.sv
// Output channel: one result beat per operation.
interface sspq_out_if;
	import sspq_pkg::*;

	logic   valid;
	logic   ready;
	value_t out_value;
	logic   got_item;
	logic   rejected;
	logic   now_empty;
	logic   now_full;

	modport source (output valid, output out_value, output got_item, output rejected,
		output now_empty, output now_full, input ready);
	modport sink (input valid, input out_value, input got_item, input rejected,
		input now_empty, input now_full, output ready);
endinterface

### sv/sspq_ctrl.sv
// Controller: accepts a beat, schedules the update, manages the result register.
module sspq_ctrl (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              in_valid,
	output logic              in_ready,
	output logic              out_valid,
	input  logic              out_ready,
	output sspq_pkg::pq_cmd_t cmd
);
	import sspq_pkg::*;

	localparam logic ST_IDLE = 1'b0;
	localparam logic ST_EXEC = 1'b1;

	logic state_q;
	logic out_valid_q;

	assign in_ready  = (state_q == ST_IDLE);
	assign out_valid = out_valid_q;
	assign cmd.load  = in_valid && in_ready;
	assign cmd.exec  = (state_q == ST_EXEC) && (!out_valid_q || out_ready);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			out_valid_q <= 1'b0;
		end else begin
			case (state_q)
				ST_IDLE: begin
					if (cmd.load) begin
						state_q <= ST_EXEC;
					end
				end
				ST_EXEC: begin
					if (cmd.exec) begin
						state_q <= ST_IDLE;
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
			if (cmd.exec) begin
				out_valid_q <= 1'b1;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end
endmodule

### sv/sspq_dp.sv
// Datapath: sorted slot chain with parallel compare, shift insert/extract, result register.
module sspq_dp #(
	parameter int DEPTH = sspq_pkg::DEPTH_DEF
) (
	input  logic              clk,
	input  logic              arst_n,
	input  sspq_pkg::pq_cmd_t cmd,
	input  logic              mode,
	input  sspq_pkg::value_t  item_value,
	input  sspq_pkg::prio_t   item_priority,
	output sspq_pkg::value_t  out_value,
	output logic              got_item,
	output logic              rejected,
	output logic              now_empty,
	output logic              now_full
);
	import sspq_pkg::*;

	localparam int CNT_W = $clog2(DEPTH + 1);

	logic             mode_q;
	value_t           val_q;
	prio_t            prio_q;
	logic [CNT_W-1:0] count_q;
	logic [CNT_W-1:0] count_next;

	value_t           slot_value_q    [DEPTH];
	prio_t            slot_priority_q [DEPTH];
	value_t           slot_value_next [DEPTH];
	prio_t            slot_prio_next  [DEPTH];
	logic [DEPTH-1:0] stay;

	logic   is_full;
	logic   is_empty;
	value_t res_value;
	logic   res_got;
	logic   res_rej;

	value_t out_value_q;
	logic   got_q;
	logic   rej_q;
	logic   empty_q;
	logic   full_q;

	assign is_full  = (count_q == CNT_W'(DEPTH));
	assign is_empty = (count_q == '0);

	always_comb begin
		for (int k = 0; k < DEPTH; k++) begin
			stay[k] = (CNT_W'(k) < count_q) && (slot_priority_q[k] <= prio_q);
		end
	end

	always_comb begin
		for (int k = 0; k < DEPTH; k++) begin
			slot_value_next[k] = slot_value_q[k];
			slot_prio_next[k]  = slot_priority_q[k];
		end
		count_next = count_q;
		res_value  = EMPTY_VALUE;
		res_got    = 1'b0;
		res_rej    = 1'b0;
		if (mode_q == MODE_INSERT) begin
			if (is_full) begin
				res_rej = 1'b1;
			end else begin
				count_next = count_q + CNT_W'(1);
				if (!stay[0]) begin
					slot_value_next[0] = val_q;
					slot_prio_next[0]  = prio_q;
				end
				for (int k = 1; k < DEPTH; k++) begin
					if (stay[k]) begin
						slot_value_next[k] = slot_value_q[k];
						slot_prio_next[k]  = slot_priority_q[k];
					end else if (stay[k-1]) begin
						slot_value_next[k] = val_q;
						slot_prio_next[k]  = prio_q;
					end else begin
						slot_value_next[k] = slot_value_q[k-1];
						slot_prio_next[k]  = slot_priority_q[k-1];
					end
				end
			end
		end else begin
			if (!is_empty) begin
				count_next = count_q - CNT_W'(1);
				res_value  = slot_value_q[0];
				res_got    = 1'b1;
				for (int k = 0; k < DEPTH - 1; k++) begin
					slot_value_next[k] = slot_value_q[k+1];
					slot_prio_next[k]  = slot_priority_q[k+1];
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.load) begin
			mode_q <= mode;
			val_q  <= item_value;
			prio_q <= item_priority;
		end
		if (cmd.exec) begin
			for (int k = 0; k < DEPTH; k++) begin
				slot_value_q[k]    <= slot_value_next[k];
				slot_priority_q[k] <= slot_prio_next[k];
			end
			out_value_q <= res_value;
			got_q       <= res_got;
			rej_q       <= res_rej;
			empty_q     <= (count_next == '0);
			full_q      <= (count_next == CNT_W'(DEPTH));
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			count_q <= '0;
		end else if (cmd.exec) begin
			count_q <= count_next;
		end
	end

	assign out_value = out_value_q;
	assign got_item  = got_q;
	assign rejected  = rej_q;
	assign now_empty = empty_q;
	assign now_full  = full_q;
endmodule

### sv/stable_sorted_priority_queue.sv
// Stable sorted min-priority queue, top level.
// An accepted input beat is held in the operand registers; in the exec state the slot chain
// and result register update on a parallel compare of all DEPTH slots, and the result
// beat becomes valid. The next input beat is taken only on return to idle.
// A pending result stalls the update until the output register is taken.
// Reset (arst_n low, asynchronous) empties the queue; slot contents are not cleared.
module stable_sorted_priority_queue #(
	parameter int DEPTH = sspq_pkg::DEPTH_DEF
) (
	input  logic       clk,
	input  logic       arst_n,
	sspq_in_if.sink    in_ch,
	sspq_out_if.source out_ch
);
	import sspq_pkg::*;

	pq_cmd_t cmd;

	sspq_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_ch.valid),
		.in_ready  (in_ch.ready),
		.out_valid (out_ch.valid),
		.out_ready (out_ch.ready),
		.cmd       (cmd)
	);

	sspq_dp #(
		.DEPTH (DEPTH)
	) u_dp (
		.clk           (clk),
		.arst_n        (arst_n),
		.cmd           (cmd),
		.mode          (in_ch.mode),
		.item_value    (in_ch.item_value),
		.item_priority (in_ch.item_priority),
		.out_value     (out_ch.out_value),
		.got_item      (out_ch.got_item),
		.rejected      (out_ch.rejected),
		.now_empty     (out_ch.now_empty),
		.now_full      (out_ch.now_full)
	);
endmodule

### sv/sspq_checker.sv
// Port-level checker for the priority queue, bound to the top level.
module sspq_checker (
	input logic             clk,
	input logic             arst_n,
	input logic             out_valid,
	input logic             out_ready,
	input sspq_pkg::value_t out_value,
	input logic             got_item,
	input logic             rejected,
	input logic             now_empty,
	input logic             now_full
);
	import sspq_pkg::*;

	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> out_valid && $stable(out_value))
		else $error("result beat changed while stalled");

	a_got_rej: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> !(got_item && rejected))
		else $error("beat both removed and rejected");

	a_got_not_full: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && got_item |-> !now_full)
		else $error("queue full after removing an entry");

	a_rej_full: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && rejected |-> now_full && !now_empty)
		else $error("insert dropped while queue not full");

	a_no_item_value: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !got_item |-> out_value == EMPTY_VALUE)
		else $error("value returned without a removed entry");
endmodule

bind stable_sorted_priority_queue sspq_checker u_sspq_checker (
	.clk       (clk),
	.arst_n    (arst_n),
	.out_valid (out_ch.valid),
	.out_ready (out_ch.ready),
	.out_value (out_ch.out_value),
	.got_item  (out_ch.got_item),
	.rejected  (out_ch.rejected),
	.now_empty (out_ch.now_empty),
	.now_full  (out_ch.now_full)
);
